/* hw/rtl/press_code_gate_lock_core_defines.svh */
// assertion macros shared by the press code gate lock checker
`ifndef PRESS_CODE_GATE_LOCK_CORE_DEFINES_SVH
`define PRESS_CODE_GATE_LOCK_CORE_DEFINES_SVH

// same-cycle implication, idle while reset is high
`define PCGL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, idle while reset is high
`define PCGL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/pcgl_pkg.sv */
// package with types, register map and defaults of the press code gate lock
package pcgl_pkg;

  // one input word: button levels of one tick
  typedef struct packed {
    logic inner_pressed;
    logic outer_pressed;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic       open_drive;
    logic       close_drive;
    logic       gate_busy;
    logic [3:0] code_progress;
  } out_word_t;

  // tick kind decided in the front
  typedef enum logic [1:0] {
    KIND_RELEASE = 2'd0,
    KIND_OUTER   = 2'd1,
    KIND_INNER   = 2'd2
  } kind_t;

  // front to engine link
  typedef struct packed {
    logic  valid;
    kind_t kind;
  } feed_t;

  // configuration register set
  typedef struct packed {
    logic [7:0]  short_ticks;
    logic [7:0]  long_ticks;
    logic [15:0] idle_ticks;
    logic [15:0] pulse_ticks;
    logic [15:0] open_wait_ticks;
    logic [15:0] close_wait_ticks;
    logic [3:0]  code_length;
    logic [14:0] code_pattern;
  } cfg_t;

  // register indexes (byte address is four times the index)
  localparam int unsigned ADDR_W = 5;
  typedef enum logic [2:0] {
    REG_SHORT_TICKS      = 3'd0,
    REG_LONG_TICKS       = 3'd1,
    REG_IDLE_TICKS       = 3'd2,
    REG_PULSE_TICKS      = 3'd3,
    REG_OPEN_WAIT_TICKS  = 3'd4,
    REG_CLOSE_WAIT_TICKS = 3'd5,
    REG_CODE_LENGTH      = 3'd6,
    REG_CODE_PATTERN     = 3'd7
  } reg_idx_t;

  // reset values
  localparam logic [7:0]  RST_SHORT_TICKS      = 8'd2;
  localparam logic [7:0]  RST_LONG_TICKS       = 8'd100;
  localparam logic [15:0] RST_IDLE_TICKS       = 16'd1000;
  localparam logic [15:0] RST_PULSE_TICKS      = 16'd20;
  localparam logic [15:0] RST_OPEN_WAIT_TICKS  = 16'd4000;
  localparam logic [15:0] RST_CLOSE_WAIT_TICKS = 16'd600;
  localparam logic [3:0]  RST_CODE_LENGTH      = 4'd9;
  localparam logic [14:0] RST_CODE_PATTERN     = 15'd56;

  // default parameters
  localparam int unsigned MAX_CODE_SYMBOLS = 15;
  localparam int unsigned QUEUE_DEPTH      = 2;

endpackage

/* hw/rtl/pcgl_fifo.sv */
// small register queue with push/full and pop/empty sides
module pcgl_fifo #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = pcgl_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  // handshake
  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

/* hw/rtl/pcgl_front.sv */
// front: takes button words, sorts each tick into a kind and queues it
module pcgl_front #(
  parameter int unsigned DEPTH = pcgl_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  pcgl_pkg::in_word_t item,
  input  logic               feed_pop,
  output pcgl_pkg::feed_t    feed
);

  localparam int unsigned KIND_W = $bits(pcgl_pkg::kind_t);

  pcgl_pkg::kind_t   kind_in;
  logic [KIND_W-1:0] kind_out;
  logic              q_empty;

  // inner press wins, the outer button is not looked at then
  always_comb begin
    if (item.inner_pressed) begin
      kind_in = pcgl_pkg::KIND_INNER;
    end else if (item.outer_pressed) begin
      kind_in = pcgl_pkg::KIND_OUTER;
    end else begin
      kind_in = pcgl_pkg::KIND_RELEASE;
    end
  end

  // queue toward the engine
  pcgl_fifo #(
    .WIDTH (KIND_W),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .wdata (kind_in),
    .pop   (feed_pop),
    .empty (q_empty),
    .rdata (kind_out)
  );

  assign feed.valid = !q_empty;
  assign feed.kind  = pcgl_pkg::kind_t'(kind_out);

endmodule

/* hw/rtl/pcgl_regs.sv */
// configuration registers behind the apb-style port
module pcgl_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcgl_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output pcgl_pkg::cfg_t                cfg
);

  pcgl_pkg::reg_idx_t idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = pcgl_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_ticks      <= pcgl_pkg::RST_SHORT_TICKS;
      cfg.long_ticks       <= pcgl_pkg::RST_LONG_TICKS;
      cfg.idle_ticks       <= pcgl_pkg::RST_IDLE_TICKS;
      cfg.pulse_ticks      <= pcgl_pkg::RST_PULSE_TICKS;
      cfg.open_wait_ticks  <= pcgl_pkg::RST_OPEN_WAIT_TICKS;
      cfg.close_wait_ticks <= pcgl_pkg::RST_CLOSE_WAIT_TICKS;
      cfg.code_length      <= pcgl_pkg::RST_CODE_LENGTH;
      cfg.code_pattern     <= pcgl_pkg::RST_CODE_PATTERN;
    end else if (wr_en) begin
      unique case (idx)
        pcgl_pkg::REG_SHORT_TICKS:      cfg.short_ticks      <= pwdata[7:0];
        pcgl_pkg::REG_LONG_TICKS:       cfg.long_ticks       <= pwdata[7:0];
        pcgl_pkg::REG_IDLE_TICKS:       cfg.idle_ticks       <= pwdata[15:0];
        pcgl_pkg::REG_PULSE_TICKS:      cfg.pulse_ticks      <= pwdata[15:0];
        pcgl_pkg::REG_OPEN_WAIT_TICKS:  cfg.open_wait_ticks  <= pwdata[15:0];
        pcgl_pkg::REG_CLOSE_WAIT_TICKS: cfg.close_wait_ticks <= pwdata[15:0];
        pcgl_pkg::REG_CODE_LENGTH:      cfg.code_length      <= pwdata[3:0];
        pcgl_pkg::REG_CODE_PATTERN:     cfg.code_pattern     <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      pcgl_pkg::REG_SHORT_TICKS:      prdata = {24'd0, cfg.short_ticks};
      pcgl_pkg::REG_LONG_TICKS:       prdata = {24'd0, cfg.long_ticks};
      pcgl_pkg::REG_IDLE_TICKS:       prdata = {16'd0, cfg.idle_ticks};
      pcgl_pkg::REG_PULSE_TICKS:      prdata = {16'd0, cfg.pulse_ticks};
      pcgl_pkg::REG_OPEN_WAIT_TICKS:  prdata = {16'd0, cfg.open_wait_ticks};
      pcgl_pkg::REG_CLOSE_WAIT_TICKS: prdata = {16'd0, cfg.close_wait_ticks};
      pcgl_pkg::REG_CODE_LENGTH:      prdata = {28'd0, cfg.code_length};
      pcgl_pkg::REG_CODE_PATTERN:     prdata = {17'd0, cfg.code_pattern};
      default:                        prdata = 32'd0;
    endcase
  end

endmodule

/* hw/rtl/pcgl_engine.sv */
// back end: code matching, idle timeout and the open/close gate sequence
module pcgl_engine #(
  parameter int unsigned MAX_CODE_SYMBOLS = pcgl_pkg::MAX_CODE_SYMBOLS
) (
  input  logic                clk,
  input  logic                rst,
  input  pcgl_pkg::cfg_t      cfg,
  input  pcgl_pkg::feed_t     feed,
  output logic                feed_pop,
  input  logic                out_full,
  output logic                out_push,
  output pcgl_pkg::out_word_t out_word
);

  localparam logic [3:0] MAX_LEN = 4'(MAX_CODE_SYMBOLS);

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_OPEN_PULSE  = 3'd1,
    PH_OPEN_WAIT   = 3'd2,
    PH_CLOSE_PULSE = 3'd3,
    PH_CLOSE_WAIT  = 3'd4
  } phase_t;

  phase_t      phase;
  phase_t      phase_next;
  logic [15:0] phase_timer;
  logic [15:0] phase_timer_next;
  logic [7:0]  hold_count;
  logic [7:0]  hold_count_next;
  logic [15:0] idle_count;
  logic [15:0] idle_count_next;
  logic [3:0]  match_index;
  logic [3:0]  match_index_next;
  logic        step;

  // length of a phase in ticks
  function automatic logic [15:0] phase_len(input logic [2:0] ph, input pcgl_pkg::cfg_t c);
    logic [15:0] len;
    len = 16'd0;
    case (ph)
      PH_OPEN_PULSE, PH_CLOSE_PULSE: len = c.pulse_ticks;
      PH_OPEN_WAIT:                  len = c.open_wait_ticks;
      PH_CLOSE_WAIT:                 len = c.close_wait_ticks;
      default:                       len = 16'd0;
    endcase
    return len;
  endfunction

  // first phase at or after start with a nonzero length, else idle
  function automatic logic [2:0] first_phase(input logic [2:0] start, input pcgl_pkg::cfg_t c);
    logic [2:0] ph;
    logic       found;
    ph    = PH_IDLE;
    found = 1'b0;
    for (int i = 1; i <= 4; i++) begin
      if (!found && 3'(i) >= start && phase_len(3'(i), c) != 16'd0) begin
        ph    = 3'(i);
        found = 1'b1;
      end
    end
    return ph;
  endfunction

  // one tick is stepped when a word waits and the result queue has room
  assign step     = feed.valid && !out_full;
  assign feed_pop = step;
  assign out_push = step;

  // next state of one tick
  always_comb begin
    logic [15:0] timer_dec;
    logic [15:0] idle_inc;
    logic [3:0]  len;
    logic [2:0]  enter_ph;
    logic        start_seq;
    logic        has_sym;
    logic        is_long;
    logic [14:0] pat_shift;

    phase_next       = phase;
    phase_timer_next = phase_timer;
    hold_count_next  = hold_count;
    idle_count_next  = idle_count;
    match_index_next = match_index;
    timer_dec        = phase_timer;
    idle_inc         = idle_count;
    len              = (cfg.code_length > MAX_LEN) ? MAX_LEN : cfg.code_length;
    enter_ph         = 3'(PH_OPEN_PULSE);
    start_seq        = 1'b0;
    has_sym          = 1'b0;
    is_long          = 1'b0;
    pat_shift        = cfg.code_pattern >> match_index;

    if (phase != PH_IDLE) begin
      // running sequence, buttons ignored
      if (phase_timer != 16'd0) begin
        timer_dec = phase_timer - 16'd1;
      end
      phase_timer_next = timer_dec;
      if (timer_dec == 16'd0) begin
        enter_ph  = 3'(phase) + 3'd1;
        start_seq = 1'b1;
      end
    end else begin
      unique case (feed.kind)
        pcgl_pkg::KIND_INNER: begin
          hold_count_next  = 8'd0;
          idle_count_next  = 16'd0;
          match_index_next = 4'd0;
          start_seq        = 1'b1;
        end
        pcgl_pkg::KIND_OUTER: begin
          if (hold_count != 8'hFF) begin
            hold_count_next = hold_count + 8'd1;
          end
          idle_count_next = 16'd0;
        end
        default: begin
          // released tick: timeout or symbol decision
          if (idle_count != 16'hFFFF) begin
            idle_inc = idle_count + 16'd1;
          end
          idle_count_next = idle_inc;
          if (idle_inc > cfg.idle_ticks) begin
            hold_count_next  = 8'd0;
            idle_count_next  = 16'd0;
            match_index_next = 4'd0;
          end else begin
            if (hold_count > cfg.long_ticks) begin
              has_sym = 1'b1;
              is_long = 1'b1;
            end else if (hold_count > cfg.short_ticks) begin
              has_sym = 1'b1;
            end
            if (has_sym) begin
              if (match_index < len && match_index != 4'd15 && pat_shift[0] == is_long) begin
                match_index_next = match_index + 4'd1;
              end else begin
                match_index_next = 4'd0;
              end
            end
            hold_count_next = 8'd0;
            if (match_index_next != 4'd0 && match_index_next >= len) begin
              match_index_next = 4'd0;
              start_seq        = 1'b1;
            end
          end
        end
      endcase
    end

    if (start_seq) begin
      phase_next       = phase_t'(first_phase(enter_ph, cfg));
      phase_timer_next = phase_len(first_phase(enter_ph, cfg), cfg);
    end
  end

  // state registers; the result word is combinational
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      phase_timer <= 16'd0;
      hold_count  <= 8'd0;
      idle_count  <= 16'd0;
      match_index <= 4'd0;
    end else if (step) begin
      phase       <= phase_next;
      phase_timer <= phase_timer_next;
      hold_count  <= hold_count_next;
      idle_count  <= idle_count_next;
      match_index <= match_index_next;
    end
  end

  // result word of the stepped tick
  assign out_word.open_drive    = (phase_next == PH_OPEN_PULSE);
  assign out_word.close_drive   = (phase_next == PH_CLOSE_PULSE);
  assign out_word.gate_busy     = (phase_next != PH_IDLE);
  assign out_word.code_progress = match_index_next;

endmodule

/* hw/rtl/press_code_gate_lock_core.sv */
// Press code gate lock: each input word is one tick with the inner and outer button levels,
// each tick gives exactly one result word (drives, busy flag, code progress). One word per
// cycle is sustained while the result side pops: front queue, tick engine and result queue
// each move one word a cycle. A taken word is registered in the front queue, its result in
// the result queue. With QUEUE_DEPTH words of slack on each side, a stalled result side
// fills the result queue and then the input queue before full rises. Registers sit at byte
// address 4 times their index and should only be written while no words are in flight.
module press_code_gate_lock_core #(
  parameter int unsigned MAX_CODE_SYMBOLS = pcgl_pkg::MAX_CODE_SYMBOLS,
  parameter int unsigned QUEUE_DEPTH      = pcgl_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  pcgl_pkg::in_word_t          item,
  input  logic                        pop,
  output logic                        empty,
  output pcgl_pkg::out_word_t         result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcgl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned OUT_W = $bits(pcgl_pkg::out_word_t);

  pcgl_pkg::cfg_t      cfg;
  pcgl_pkg::feed_t     feed;
  logic                feed_pop;
  logic                out_full;
  logic                out_push;
  pcgl_pkg::out_word_t out_word;
  logic [OUT_W-1:0]    out_rdata;

  // configuration
  pcgl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front: classify and queue ticks
  pcgl_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .feed_pop (feed_pop),
    .feed     (feed)
  );

  // back: tick engine
  pcgl_engine #(
    .MAX_CODE_SYMBOLS (MAX_CODE_SYMBOLS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .feed     (feed),
    .feed_pop (feed_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_word (out_word)
  );

  // result queue
  pcgl_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .full  (out_full),
    .wdata (out_word),
    .pop   (pop),
    .empty (empty),
    .rdata (out_rdata)
  );

  assign result = pcgl_pkg::out_word_t'(out_rdata);

endmodule

/* hw/rtl/pcgl_checker.sv */
// port-level checker for the press code gate lock, bound to the top level
`include "press_code_gate_lock_core_defines.svh"

module pcgl_checker (
  input logic                clk,
  input logic                rst,
  input logic                pop,
  input logic                empty,
  input pcgl_pkg::out_word_t result
);

  // never both actuators at once
  `PCGL_ASSERT_IMPLY(a_one_drive, clk, rst, !empty, !(result.open_drive && result.close_drive), "open and close driven together")

  // a drive pulse only while the sequence runs
  `PCGL_ASSERT_IMPLY(a_drive_busy, clk, rst, !empty && (result.open_drive || result.close_drive), result.gate_busy, "drive without busy")

  // progress is cleared whenever the sequence runs
  `PCGL_ASSERT_IMPLY(a_busy_progress, clk, rst, !empty && result.gate_busy, result.code_progress == 4'd0, "progress kept while busy")

  // a waiting word holds until taken
  `PCGL_ASSERT_NEXT(a_hold_word, clk, rst, !empty && !pop, !empty && $stable(result), "waiting word changed")

endmodule

bind press_code_gate_lock_core pcgl_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .pop    (pop),
  .empty  (empty),
  .result (result)
);

/* tb/press_code_gate_lock_core_tb.sv */
// self-checking testbench of the press code gate lock core
`timescale 1ns / 1ps

module press_code_gate_lock_core_tb;

  // gate sequence phases as the testbench tracks them
  typedef enum logic [2:0] {
    GP_IDLE        = 3'd0,
    GP_OPEN_PULSE  = 3'd1,
    GP_OPEN_WAIT   = 3'd2,
    GP_CLOSE_PULSE = 3'd3,
    GP_CLOSE_WAIT  = 3'd4
  } gate_phase_t;

  typedef struct packed {
    logic [7:0]  hold;
    logic [15:0] idle;
    logic [3:0]  matched;
    gate_phase_t phase;
    logic [15:0] timer;
  } lock_state_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          push = 1'b0;
  logic                          full;
  pcgl_pkg::in_word_t            item = '0;
  logic                          pop = 1'b0;
  logic                          empty;
  pcgl_pkg::out_word_t           result;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [pcgl_pkg::ADDR_W-1:0]   paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // register copy shared by the tick generator and the result predictor
  pcgl_pkg::cfg_t regs;
  lock_state_t    gen_st = '0;
  lock_state_t    model_st = '0;

  pcgl_pkg::in_word_t  pending_ticks[$];
  pcgl_pkg::out_word_t due_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int rx_hold_left = 0;
  int errors = 0;
  int n_live = 0;
  int n_busy = 0;
  int chunk_live = 0;
  int phase_live = 0;
  int chunk_no = 0;
  int gate_runs = 0;
  int n_checked = 0;
  int n_settings = 0;

  press_code_gate_lock_core uut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .pop     (pop),
    .empty   (empty),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // length of a sequence phase under the current registers
  function automatic logic [15:0] stage_len(int ph);
    case (ph)
      GP_OPEN_PULSE, GP_CLOSE_PULSE: return regs.pulse_ticks;
      GP_OPEN_WAIT:                  return regs.open_wait_ticks;
      GP_CLOSE_WAIT:                 return regs.close_wait_ticks;
      default:                       return 16'd0;
    endcase
  endfunction

  // enter a phase, stepping over phases of zero length
  function automatic lock_state_t enter_stage(lock_state_t s, int ph);
    while (ph >= GP_OPEN_PULSE && ph <= GP_CLOSE_WAIT && stage_len(ph) == 16'd0) ph++;
    if (ph > GP_CLOSE_WAIT) ph = GP_IDLE;
    s.phase = gate_phase_t'(ph);
    s.timer = stage_len(ph);
    return s;
  endfunction

  // one button tick: next lock state and the result word it shows
  function automatic void lock_tick(input lock_state_t cur, input pcgl_pkg::in_word_t w,
                                    output lock_state_t nxt, output pcgl_pkg::out_word_t r);
    int len;
    bit has_sym;
    bit is_long;
    nxt = cur;
    has_sym = 1'b0;
    is_long = 1'b0;
    len = (regs.code_length > pcgl_pkg::MAX_CODE_SYMBOLS) ?
          int'(pcgl_pkg::MAX_CODE_SYMBOLS) : int'(regs.code_length);
    if (cur.phase != GP_IDLE) begin
      if (nxt.timer > 0) nxt.timer = nxt.timer - 1'b1;
      if (nxt.timer == 0) nxt = enter_stage(nxt, int'(cur.phase) + 1);
    end else if (w.inner_pressed) begin
      nxt.hold = '0;
      nxt.idle = '0;
      nxt.matched = '0;
      nxt = enter_stage(nxt, GP_OPEN_PULSE);
    end else if (w.outer_pressed) begin
      if (nxt.hold != 8'hFF) nxt.hold = nxt.hold + 1'b1;
      nxt.idle = '0;
    end else begin
      if (nxt.idle != 16'hFFFF) nxt.idle = nxt.idle + 1'b1;
      if (nxt.idle > regs.idle_ticks) begin
        // idle too long: all progress gone
        nxt.hold = '0;
        nxt.idle = '0;
        nxt.matched = '0;
      end else begin
        // release: classify the hold that just ended
        if (nxt.hold > regs.long_ticks) begin
          has_sym = 1'b1;
          is_long = 1'b1;
        end else if (nxt.hold > regs.short_ticks) begin
          has_sym = 1'b1;
        end
        if (has_sym) begin
          if (nxt.matched < len && nxt.matched < 15 &&
              regs.code_pattern[nxt.matched] == is_long)
            nxt.matched = nxt.matched + 1'b1;
          else
            nxt.matched = '0;
        end
        nxt.hold = '0;
        if (nxt.matched > 0 && nxt.matched >= len) begin
          nxt.matched = '0;
          nxt = enter_stage(nxt, GP_OPEN_PULSE);
        end
      end
    end
    r.open_drive    = (nxt.phase == GP_OPEN_PULSE);
    r.close_drive   = (nxt.phase == GP_CLOSE_PULSE);
    r.gate_busy     = (nxt.phase != GP_IDLE);
    r.code_progress = nxt.matched;
  endfunction

  function automatic logic [31:0] reg_value(pcgl_pkg::reg_idx_t idx);
    case (idx)
      pcgl_pkg::REG_SHORT_TICKS:      return 32'(regs.short_ticks);
      pcgl_pkg::REG_LONG_TICKS:       return 32'(regs.long_ticks);
      pcgl_pkg::REG_IDLE_TICKS:       return 32'(regs.idle_ticks);
      pcgl_pkg::REG_PULSE_TICKS:      return 32'(regs.pulse_ticks);
      pcgl_pkg::REG_OPEN_WAIT_TICKS:  return 32'(regs.open_wait_ticks);
      pcgl_pkg::REG_CLOSE_WAIT_TICKS: return 32'(regs.close_wait_ticks);
      pcgl_pkg::REG_CODE_LENGTH:      return 32'(regs.code_length);
      default:                        return 32'(regs.code_pattern);
    endcase
  endfunction

  // input side: offer queued ticks, predict the result of each one taken
  always @(posedge clk) begin : drv
    pcgl_pkg::out_word_t r;
    lock_state_t         nxt;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        lock_tick(model_st, item, nxt, r);
        if (r.gate_busy && model_st.phase == GP_IDLE) gate_runs++;
        model_st = nxt;
        due_results.push_back(r);
        void'(pending_ticks.pop_front());
      end
      if (push && full) begin
        // hold the offered word
      end else if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        item <= pending_ticks[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result side: check each word taken, stall at random or for a hold-off
  always @(posedge clk) begin : mon
    pcgl_pkg::out_word_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_checked++;
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %p", result);
        end else begin
          want = due_results.pop_front();
          if (result.open_drive !== want.open_drive ||
              result.close_drive !== want.close_drive ||
              result.gate_busy !== want.gate_busy ||
              result.code_progress !== want.code_progress) begin
            errors++;
            if (errors <= 10)
              $display("result %0d: open/close/busy/progress exp %b/%b/%b/%0d got %b/%b/%b/%0d",
                       n_checked, want.open_drive, want.close_drive, want.gate_busy,
                       want.code_progress, result.open_drive, result.close_drive,
                       result.gate_busy, result.code_progress);
          end
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // register access: optional write, then read back and compare
  task automatic reg_access(input pcgl_pkg::reg_idx_t idx, input bit do_write,
                            input logic [31:0] val);
    logic [31:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= do_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    if (do_write) begin
      @(posedge clk);
      penable <= 1'b1;
      @(negedge clk);
      while (!pready) @(negedge clk);
      @(posedge clk);
      case (idx)
        pcgl_pkg::REG_SHORT_TICKS:      regs.short_ticks = val[7:0];
        pcgl_pkg::REG_LONG_TICKS:       regs.long_ticks = val[7:0];
        pcgl_pkg::REG_IDLE_TICKS:       regs.idle_ticks = val[15:0];
        pcgl_pkg::REG_PULSE_TICKS:      regs.pulse_ticks = val[15:0];
        pcgl_pkg::REG_OPEN_WAIT_TICKS:  regs.open_wait_ticks = val[15:0];
        pcgl_pkg::REG_CLOSE_WAIT_TICKS: regs.close_wait_ticks = val[15:0];
        pcgl_pkg::REG_CODE_LENGTH:      regs.code_length = val[3:0];
        default:                        regs.code_pattern = val[14:0];
      endcase
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    got = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== reg_value(idx)) begin
      errors++;
      if (errors <= 10)
        $display("register %s: exp %h got %h", idx.name(), reg_value(idx), got);
    end
  endtask

  task automatic setup(input logic [31:0] s, l, i, p, ow, cw, len, pat);
    reg_access(pcgl_pkg::REG_SHORT_TICKS, 1'b1, s);
    reg_access(pcgl_pkg::REG_LONG_TICKS, 1'b1, l);
    reg_access(pcgl_pkg::REG_IDLE_TICKS, 1'b1, i);
    reg_access(pcgl_pkg::REG_PULSE_TICKS, 1'b1, p);
    reg_access(pcgl_pkg::REG_OPEN_WAIT_TICKS, 1'b1, ow);
    reg_access(pcgl_pkg::REG_CLOSE_WAIT_TICKS, 1'b1, cw);
    reg_access(pcgl_pkg::REG_CODE_LENGTH, 1'b1, len);
    reg_access(pcgl_pkg::REG_CODE_PATTERN, 1'b1, pat);
    n_settings++;
  endtask

  // idling profile; also moves the caller off the rising edge
  task automatic set_mode(input int mode);
    @(negedge clk);
    case (mode)
      1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
      3: begin send_idle_pct = 20; recv_stall_pct = 20; end
      4: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rx_hold_left = $urandom_range(80, 30);
      end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  task automatic wait_sent();
    while (pending_ticks.size() != 0) @(negedge clk);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    while (pending_ticks.size() != 0 || push || due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_tick(input bit inner, input bit outer);
    pcgl_pkg::in_word_t  w;
    pcgl_pkg::out_word_t r;
    lock_state_t         nxt;
    w.inner_pressed = inner;
    w.outer_pressed = outer;
    if (gen_st.phase == GP_IDLE) begin
      n_live++;
      chunk_live++;
      phase_live++;
    end else begin
      n_busy++;
    end
    lock_tick(gen_st, w, nxt, r);
    gen_st = nxt;
    pending_ticks.push_back(w);
  endtask

  // random buttons while the gate runs
  task automatic fill_busy();
    while (gen_st.phase != GP_IDLE)
      queue_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic queue_hold(input int n);
    repeat (n) queue_tick(1'b0, 1'b1);
    queue_tick(1'b0, 1'b0);
    fill_busy();
  endtask

  // one well-formed symbol with a release gap inside the idle limit
  task automatic queue_symbol(input bit lng);
    int lo;
    int hi;
    int n;
    int gap;
    if (lng) begin
      n = regs.long_ticks + 1 + $urandom_range(2);
    end else begin
      lo = regs.short_ticks + 1;
      hi = (regs.long_ticks >= lo) ? int'(regs.long_ticks) : lo;
      if (hi > lo + 8) hi = lo + 8;
      n = $urandom_range(hi, lo);
    end
    repeat (n) queue_tick(1'b0, 1'b1);
    queue_tick(1'b0, 1'b0);
    gap = (regs.idle_ticks > 2) ? 2 : int'(regs.idle_ticks) - 1;
    if (gap > 0) repeat ($urandom_range(gap)) queue_tick(1'b0, 1'b0);
    fill_busy();
  endtask

  // the configured code, each symbol now and then flipped
  task automatic queue_code();
    bit lng;
    for (int k = 0; k < regs.code_length && k < 15; k++) begin
      lng = regs.code_pattern[k];
      if ($urandom_range(19) == 0) lng = !lng;
      queue_symbol(lng);
    end
  endtask

  task automatic queue_noise();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 8) begin
      queue_tick(1'b1, 1'($urandom_range(1)));
      fill_busy();
    end else if (pick < 20 && regs.idle_ticks <= 300) begin
      repeat (regs.idle_ticks + 1 + $urandom_range(2)) queue_tick(1'b0, 1'b0);
    end else begin
      n = regs.long_ticks + 4;
      if (n > 300) n = 300;
      repeat ($urandom_range(n)) queue_tick(1'b0, 1'b1);
      repeat ($urandom_range(3, 1)) queue_tick(1'b0, 1'b0);
      fill_busy();
    end
  endtask

  // mostly valid codes, in chunks that rotate the idling profile
  task automatic random_phase(input int target);
    phase_live = 0;
    while (phase_live < target) begin
      set_mode(chunk_no % 5);
      chunk_live = 0;
      while (chunk_live < 60) begin
        if ($urandom_range(99) < 65) queue_code();
        else queue_noise();
      end
      wait_sent();
      chunk_no++;
    end
    wait_drain();
  endtask

  // run limit
  initial begin
    #(30_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  // stimulus
  initial begin
    regs.short_ticks      = pcgl_pkg::RST_SHORT_TICKS;
    regs.long_ticks       = pcgl_pkg::RST_LONG_TICKS;
    regs.idle_ticks       = pcgl_pkg::RST_IDLE_TICKS;
    regs.pulse_ticks      = pcgl_pkg::RST_PULSE_TICKS;
    regs.open_wait_ticks  = pcgl_pkg::RST_OPEN_WAIT_TICKS;
    regs.close_wait_ticks = pcgl_pkg::RST_CLOSE_WAIT_TICKS;
    regs.code_length      = pcgl_pkg::RST_CODE_LENGTH;
    regs.code_pattern     = pcgl_pkg::RST_CODE_PATTERN;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset values, then a short symbol under them
    for (int i = 0; i < 8; i++) reg_access(pcgl_pkg::reg_idx_t'(i), 1'b0, 32'd0);
    set_mode(0);
    queue_hold(3);
    queue_tick(1'b0, 1'b0);
    wait_drain();

    // directed: short then long completes a two-symbol code
    setup(2, 4, 3, 2, 3, 2, 2, 32'h2);
    set_mode(0);
    queue_tick(1'b0, 1'b0);
    queue_hold(3);
    queue_hold(5);
    queue_hold(2);          // exactly the short limit: no symbol
    queue_hold(5);          // long where short is due: no progress
    queue_tick(1'b1, 1'b1); // inner press wins over the outer button
    fill_busy();
    queue_hold(3);
    repeat (4) queue_tick(1'b0, 1'b0); // idle limit passed
    wait_drain();

    // progress left above a shortened code: bare release completes
    setup(2, 6, 20, 1, 1, 1, 4, 0);
    set_mode(0);
    repeat (3) queue_symbol(1'b0);
    wait_drain();
    reg_access(pcgl_pkg::REG_CODE_LENGTH, 1'b1, 2);
    set_mode(0);
    queue_tick(1'b0, 1'b0);
    fill_busy();
    wait_drain();
    // same, but a symbol arrives: counts as wrong
    reg_access(pcgl_pkg::REG_CODE_LENGTH, 1'b1, 4);
    set_mode(0);
    repeat (3) queue_symbol(1'b0);
    wait_drain();
    reg_access(pcgl_pkg::REG_CODE_LENGTH, 1'b1, 2);
    set_mode(0);
    queue_symbol(1'b0);
    queue_tick(1'b0, 1'b0);
    wait_drain();

    // random codes over several register settings
    setup(2, 6, 20, 1, 2, 1, 3, $urandom_range(32767));
    random_phase(120);
    setup(0, 1, 1, 3, 0, 0, 1, $urandom_range(32767));
    random_phase(120);
    setup(5, 12, 40, 2, 5, 3, 15, 32'h7FFF);
    random_phase(120);
    setup(3, 8, 30, 0, 4, 0, 4, $urandom_range(32767));   // pulses skipped
    random_phase(120);
    setup(1, 3, 6, 0, 0, 0, 2, $urandom_range(32767));    // no phase at all
    random_phase(120);
    setup(2, 5, 10, 1, 1, 1, 0, $urandom_range(32767));   // empty code
    random_phase(120);
    setup(254, 255, 300, 2, 2, 2, 2, 0);                  // hold saturation
    random_phase(120);
    setup(4, 10, 65534, 5, 10, 5, 8, 0);
    random_phase(120);

    // widest idle limit: progress survives a long release, then an inner press
    setup(255, 0, 65535, 3, 2, 3, 15, 32'h7FFF);
    set_mode(0);
    queue_hold(1);
    repeat (200) queue_tick(1'b0, 1'b0);
    queue_tick(1'b1, 1'b0);
    fill_busy();
    queue_tick(1'b0, 1'b0);
    wait_drain();

    repeat (10) @(posedge clk);
    $display("covered %0d ticks at rest and %0d during gate runs, %0d gate runs, %0d settings",
             n_live, n_busy, gate_runs, n_settings);
    $display("%0d result words checked, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/pcgl_pkg.sv
hw/rtl/pcgl_fifo.sv
hw/rtl/pcgl_front.sv
hw/rtl/pcgl_regs.sv
hw/rtl/pcgl_engine.sv
hw/rtl/press_code_gate_lock_core.sv
hw/rtl/pcgl_checker.sv
tb/press_code_gate_lock_core_tb.sv
